@@ sv/owtsc_pkg.sv @@
// Types, codes and arithmetic helpers shared by the scratchpad checker.
package owtsc_pkg;

   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_BYTE = 2'd1;
   localparam logic [1:0] CMD_FAIL = 2'd2;

   localparam logic [7:0] CRC_POLY        = 8'h8C;
   localparam logic [7:0] ERR_LIMIT_RESET = 8'd3;
   localparam logic [7:0] ERR_CNT_MAX     = 8'hFF;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_DEVICE = 3'd1,
      ST_TIMEOUT   = 3'd2,
      ST_READ_ERR  = 3'd3,
      ST_CRC_ERR   = 3'd4,
      ST_REJECTED  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      LINK_UNINIT  = 3'b001,
      LINK_ONLINE  = 3'b010,
      LINK_OFFLINE = 3'b100
   } link_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       presence;
      logic       failure_kind;
   } item_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] temperature_centi;
      logic               online;
      logic [7:0]         error_count;
      logic               cached_valid;
   } result_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] b);
      logic [7:0] c;
      logic       mix;
      c = crc_i;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ b[k];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic signed [15:0] to_centi(input logic [7:0] lo, input logic [7:0] hi);
      logic signed [15:0] raw;
      logic signed [23:0] prod;
      logic signed [23:0] adj;
      logic signed [23:0] q;
      raw  = signed'({hi, lo});
      prod = 24'(raw) * 24'sd100;
      adj  = prod + (prod[23] ? 24'sd15 : 24'sd0);
      q    = adj >>> 4;
      if (q > 24'sd32767) begin
         return 16'sh7FFF;
      end else if (q < -24'sd32768) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

endpackage

@@ sv/owtsc_ifs.sv @@
// Handshake channel interfaces for request, response and register write.
interface owtsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   logic       presence;
   logic       failure_kind;
   modport source (output valid, cmd, data_byte, presence, failure_kind, input ready);
   modport sink (input valid, cmd, data_byte, presence, failure_kind, output ready);
endinterface

interface owtsc_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic signed [15:0] temperature_centi;
   logic              online;
   logic [7:0]        error_count;
   logic              cached_valid;
   modport source (output valid, status, temperature_centi, online, error_count,
                   cached_valid, input ready);
   modport sink (input valid, status, temperature_centi, online, error_count,
                 cached_valid, output ready);
endinterface

interface owtsc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] error_limit;
   modport source (output valid, error_limit, input ready);
   modport sink (input valid, error_limit, output ready);
endinterface

@@ sv/owtsc_core.sv @@
// Frame state, CRC, checks, error counting and temperature cache.
module owtsc_core
   import owtsc_pkg::*;
#(
   parameter int FRAME_BYTES = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  logic [7:0] error_limit,
   output logic       res_valid,
   output result_type res
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   link_type           link_ff, link_in;
   logic [7:0]         err_cnt_ff, err_cnt_in;
   logic [7:0]         crc_ff, crc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               ones_ff, ones_in;
   logic               zeros_ff, zeros_in;
   logic [7:0]         raw_lo_ff, raw_lo_in;
   logic [7:0]         raw_hi_ff, raw_hi_in;
   logic signed [15:0] temp_ff, temp_in;
   logic               cache_ok_ff, cache_ok_in;

   logic [7:0]         cnt_inc;
   logic               ones_upd;
   logic               zeros_upd;
   status_type         status;

   always_comb begin
      link_in     = link_ff;
      err_cnt_in  = err_cnt_ff;
      crc_in      = crc_ff;
      idx_in      = idx_ff;
      ones_in     = ones_ff;
      zeros_in    = zeros_ff;
      raw_lo_in   = raw_lo_ff;
      raw_hi_in   = raw_hi_ff;
      temp_in     = temp_ff;
      cache_ok_in = cache_ok_ff;
      res_valid   = 1'b0;
      status      = ST_OK;

      cnt_inc   = (err_cnt_ff == ERR_CNT_MAX) ? err_cnt_ff : err_cnt_ff + 8'd1;
      ones_upd  = ones_ff & (item.data_byte == 8'hFF);
      zeros_upd = zeros_ff & (item.data_byte == 8'h00);

      case (item.cmd) inside
         CMD_INIT: begin
            crc_in    = '0;
            idx_in    = '0;
            ones_in   = 1'b1;
            zeros_in  = 1'b1;
            res_valid = 1'b1;
            if (item.presence) begin
               link_in    = LINK_ONLINE;
               err_cnt_in = '0;
               status     = ST_OK;
            end else begin
               link_in = LINK_OFFLINE;
               status  = ST_NO_DEVICE;
            end
         end
         CMD_BYTE, CMD_FAIL: begin
            if (link_ff != LINK_ONLINE) begin
               res_valid = 1'b1;
               status    = ST_REJECTED;
            end else if (item.cmd == CMD_FAIL) begin
               crc_in     = '0;
               idx_in     = '0;
               ones_in    = 1'b1;
               zeros_in   = 1'b1;
               err_cnt_in = cnt_inc;
               if (cnt_inc >= error_limit) begin
                  link_in = LINK_OFFLINE;
               end
               res_valid = 1'b1;
               status    = item.failure_kind ? ST_TIMEOUT : ST_NO_DEVICE;
            end else begin
               if (idx_ff == IDX_W'(0)) begin
                  raw_lo_in = item.data_byte;
               end
               if (idx_ff == IDX_W'(1)) begin
                  raw_hi_in = item.data_byte;
               end
               if (idx_ff != LAST_IDX) begin
                  ones_in  = ones_upd;
                  zeros_in = zeros_upd;
                  crc_in   = crc8_byte(crc_ff, item.data_byte);
                  idx_in   = idx_ff + IDX_W'(1);
               end else begin
                  crc_in    = '0;
                  idx_in    = '0;
                  ones_in   = 1'b1;
                  zeros_in  = 1'b1;
                  res_valid = 1'b1;
                  if (ones_upd || zeros_upd || (crc_ff != item.data_byte)) begin
                     err_cnt_in = cnt_inc;
                     if (cnt_inc >= error_limit) begin
                        link_in = LINK_OFFLINE;
                     end
                     status = (ones_upd || zeros_upd) ? ST_READ_ERR : ST_CRC_ERR;
                  end else begin
                     err_cnt_in  = '0;
                     temp_in     = to_centi(raw_lo_ff, raw_hi_ff);
                     cache_ok_in = 1'b1;
                     status      = ST_OK;
                  end
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase

      res.status            = status;
      res.temperature_centi = temp_in;
      res.online            = (link_in == LINK_ONLINE);
      res.error_count       = err_cnt_in;
      res.cached_valid      = cache_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff     <= LINK_UNINIT;
         err_cnt_ff  <= '0;
         crc_ff      <= '0;
         idx_ff      <= '0;
         ones_ff     <= 1'b1;
         zeros_ff    <= 1'b1;
         temp_ff     <= '0;
         cache_ok_ff <= 1'b0;
      end else if (advance) begin
         link_ff     <= link_in;
         err_cnt_ff  <= err_cnt_in;
         crc_ff      <= crc_in;
         idx_ff      <= idx_in;
         ones_ff     <= ones_in;
         zeros_ff    <= zeros_in;
         temp_ff     <= temp_in;
         cache_ok_ff <= cache_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         raw_lo_ff <= raw_lo_in;
         raw_hi_ff <= raw_hi_in;
      end
   end

endmodule

@@ sv/onewire_temp_scratchpad_checker.sv @@
// An accepted item waits in the input register; any response it yields is registered in the response register.
// Throughput: one item per cycle; the input register and the response register
// advance together whenever the response register is empty or being taken.
// Reset: synchronous, active high; link uninitialised, counters and CRC cleared,
// cache empty, error_limit back to 3.
// Top level of the scratchpad checker: input register, core and response register.
module onewire_temp_scratchpad_checker
   import owtsc_pkg::*;
#(
   parameter int FRAME_BYTES = 9
) (
   input  logic         clock,
   input  logic         reset,
   owtsc_req_if.sink    req,
   owtsc_rsp_if.source  rsp,
   owtsc_csr_if.sink    csr
);

   item_type   item_ff;
   logic       in_vld_ff;
   logic       out_vld_ff;
   result_type out_ff;
   logic [7:0] error_limit_ff;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff <= ERR_LIMIT_RESET;
      end else if (csr.valid) begin
         error_limit_ff <= csr.error_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req.ready) begin
         in_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.cmd          <= req.cmd;
         item_ff.data_byte    <= req.data_byte;
         item_ff.presence     <= req.presence;
         item_ff.failure_kind <= req.failure_kind;
      end
   end

   owtsc_core #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item_ff),
      .error_limit(error_limit_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= res_valid;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp.valid             = out_vld_ff;
   assign rsp.status            = out_ff.status;
   assign rsp.temperature_centi = out_ff.temperature_centi;
   assign rsp.online            = out_ff.online;
   assign rsp.error_count       = out_ff.error_count;
   assign rsp.cached_valid      = out_ff.cached_valid;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && in_vld_ff) |-> advance)
      else $error("input register overwritten before advancing");

   a_rejected_offline: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_REJECTED) |-> !rsp.online)
      else $error("rejected item reported while online");

   a_ok_online: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_OK) |-> (rsp.online && rsp.error_count == 8'd0))
      else $error("ok item without online link and cleared count");

   a_empty_cache: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.cached_valid) |-> (rsp.temperature_centi == 16'sd0))
      else $error("temperature non-zero with empty cache");
`endif

endmodule

@@ tb/onewire_temp_scratchpad_checker_test.sv @@
// Self-checking bench for the one-wire scratchpad checker: bus events in, predicted status reports.
module onewire_temp_scratchpad_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import owtsc_pkg::*;

   localparam int FRAME_LEN  = 9;
   localparam int LATENCY    = 2;
   localparam int LONG_HOLD  = 60;

   localparam int FR_GOOD    = 0;
   localparam int FR_BAD_CRC = 1;
   localparam int FR_ALL_FF  = 2;
   localparam int FR_ALL_00  = 3;
   localparam int FR_CUT     = 4;

   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic clock;
   logic reset;

   owtsc_req_if req_if ();
   owtsc_rsp_if rsp_if ();
   owtsc_csr_if csr_if ();

   onewire_temp_scratchpad_checker #(
      .FRAME_BYTES(FRAME_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   item_type   bus_events [$];
   result_type expected_reports [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked   = 0;
   int holds_taken;
   int hold_left;
   int errors        = 0;
   int events_queued = 0;
   int events_taken  = 0;
   int reports_seen  = 0;
   int limit_writes  = 0;

   // predicted block state
   logic [7:0]         fail_limit;
   link_type           link;
   logic [7:0]         fail_run;
   logic [7:0]         crc_acc;
   logic [3:0]         frame_pos;
   logic               all_ff;
   logic               all_00;
   logic [7:0]         raw_lo;
   logic [7:0]         raw_hi;
   logic signed [15:0] cached_centi;
   logic               cache_ok;

   function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic signed [15:0] centi_of(input logic [7:0] lo_b, input logic [7:0] hi_b);
      int raw_v;
      int scaled;
      raw_v  = $signed({hi_b, lo_b});
      scaled = (raw_v * 100) / 16;
      if (scaled > 32767) begin
         scaled = 32767;
      end else if (scaled < -32768) begin
         scaled = -32768;
      end
      return scaled[15:0];
   endfunction

   function automatic void restart_frame();
      crc_acc   = 8'h00;
      frame_pos = 4'd0;
      all_ff    = 1'b1;
      all_00    = 1'b1;
   endfunction

   function automatic void note_failure();
      if (fail_run != 8'hFF) begin
         fail_run = fail_run + 8'd1;
      end
      if (fail_run >= fail_limit) begin
         link = LINK_OFFLINE;
      end
   endfunction

   function automatic bit scratchpad_step(input item_type ev, output result_type r);
      status_type st;
      logic       bad_read;
      logic       bad_crc;
      r  = '0;
      st = ST_OK;
      case (ev.cmd)
         CMD_INIT: begin
            restart_frame();
            if (!ev.presence) begin
               link = LINK_OFFLINE;
               st   = ST_NO_DEVICE;
            end else begin
               link     = LINK_ONLINE;
               fail_run = 8'd0;
            end
         end
         CMD_BYTE, CMD_FAIL: begin
            if (link != LINK_ONLINE) begin
               st = ST_REJECTED;
            end else if (ev.cmd == CMD_FAIL) begin
               restart_frame();
               note_failure();
               st = ev.failure_kind ? ST_TIMEOUT : ST_NO_DEVICE;
            end else begin
               if (ev.data_byte != 8'hFF) all_ff = 1'b0;
               if (ev.data_byte != 8'h00) all_00 = 1'b0;
               if (frame_pos == 4'd0) raw_lo = ev.data_byte;
               if (frame_pos == 4'd1) raw_hi = ev.data_byte;
               if (int'(frame_pos) + 1 < FRAME_LEN) begin
                  crc_acc   = crc8_fold(crc_acc, ev.data_byte);
                  frame_pos = frame_pos + 4'd1;
                  return 1'b0;
               end
               bad_read = all_ff || all_00;
               bad_crc  = crc_acc != ev.data_byte;
               restart_frame();
               if (bad_read) begin
                  note_failure();
                  st = ST_READ_ERR;
               end else if (bad_crc) begin
                  note_failure();
                  st = ST_CRC_ERR;
               end else begin
                  fail_run     = 8'd0;
                  cached_centi = centi_of(raw_lo, raw_hi);
                  cache_ok     = 1'b1;
               end
            end
         end
         default: return 1'b0;
      endcase
      r.status            = st;
      r.temperature_centi = cached_centi;
      r.online            = link == LINK_ONLINE;
      r.error_count       = fail_run;
      r.cached_valid      = cache_ok;
      return 1'b1;
   endfunction

   task automatic flag_field(input string what, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      end
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_INIT;
      req_if.data_byte    = 8'h00;
      req_if.presence     = 1'b0;
      req_if.failure_kind = 1'b0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.error_limit  = ERR_LIMIT_RESET;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : drive_req
      item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (bus_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = bus_events.pop_front();
            req_if.valid        <= 1'b1;
            req_if.cmd          <= nxt.cmd;
            req_if.data_byte    <= nxt.data_byte;
            req_if.presence     <= nxt.presence;
            req_if.failure_kind <= nxt.failure_kind;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
         holds_taken  <= 0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_taken != holds_asked) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         holds_taken  <= holds_taken + 1;
      end else begin
         rsp_if.ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin : watch
      item_type   ev;
      result_type want;
      if (reset) begin
         fail_limit   = ERR_LIMIT_RESET;
         link         = LINK_UNINIT;
         fail_run     = 8'd0;
         raw_lo       = 8'h00;
         raw_hi       = 8'h00;
         cached_centi = 16'sd0;
         cache_ok     = 1'b0;
         restart_frame();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            fail_limit = csr_if.error_limit;
         end
         if (req_if.valid && req_if.ready) begin
            ev.cmd          = req_if.cmd;
            ev.data_byte    = req_if.data_byte;
            ev.presence     = req_if.presence;
            ev.failure_kind = req_if.failure_kind;
            events_taken++;
            if (scratchpad_step(ev, want)) begin
               expected_reports.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               errors++;
               $display("%0t: unexpected report, expected none, got status %0d", $time,
                        rsp_if.status);
            end else begin
               want = expected_reports.pop_front();
               flag_field("status", 16'(want.status), 16'(rsp_if.status));
               flag_field("temperature_centi", want.temperature_centi,
                          rsp_if.temperature_centi);
               flag_field("online", 16'(want.online), 16'(rsp_if.online));
               flag_field("error_count", 16'(want.error_count), 16'(rsp_if.error_count));
               flag_field("cached_valid", 16'(want.cached_valid), 16'(rsp_if.cached_valid));
            end
         end
      end
   end

   task automatic push_event(input logic [1:0] c, input logic [7:0] b, input logic p,
                             input logic k);
      item_type ev;
      ev.cmd          = c;
      ev.data_byte    = b;
      ev.presence     = p;
      ev.failure_kind = k;
      bus_events.push_back(ev);
      if (c != CMD_SPARE) begin
         events_queued++;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_event(CMD_BYTE, b, 1'($urandom), 1'($urandom));
   endtask

   task automatic push_init(input logic p);
      push_event(CMD_INIT, 8'($urandom), p, 1'($urandom));
   endtask

   task automatic push_fail(input logic k);
      push_event(CMD_FAIL, 8'($urandom), 1'($urandom), k);
   endtask

   function automatic logic [15:0] pick_raw();
      logic [15:0] corners [10];
      corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0550,
                  16'hFC90, 16'h1400, 16'h147F, 16'hEB80, 16'hEB7F};
      if ($urandom_range(3) == 0) begin
         return corners[$urandom_range(9)];
      end
      return 16'($urandom);
   endfunction

   task automatic queue_frame(input int kind, input logic [15:0] raw);
      logic [7:0] bytes_v [FRAME_LEN];
      logic [7:0] crc_v;
      int         cut;
      crc_v = 8'h00;
      for (int i = 0; i < FRAME_LEN; i++) begin
         bytes_v[i] = (i == 0) ? raw[7:0] : (i == 1) ? raw[15:8] : 8'($urandom);
         if (kind == FR_ALL_FF) bytes_v[i] = 8'hFF;
         if (kind == FR_ALL_00) bytes_v[i] = 8'h00;
         if (i < FRAME_LEN - 1) crc_v = crc8_fold(crc_v, bytes_v[i]);
      end
      if (kind == FR_GOOD) bytes_v[FRAME_LEN - 1] = crc_v;
      if (kind == FR_BAD_CRC) bytes_v[FRAME_LEN - 1] = crc_v ^ (8'h01 << $urandom_range(7));
      cut = (kind == FR_CUT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
      for (int i = 0; i < cut; i++) begin
         push_byte(bytes_v[i]);
      end
      if (kind == FR_CUT) begin
         if ($urandom_range(1)) begin
            push_fail(1'($urandom));
         end else begin
            push_init(1'b1);
         end
      end
   endtask

   task automatic random_traffic(input int quota);
      int start;
      int pick;
      int kind;
      start = events_queued;
      while (events_queued - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            if ($urandom_range(3) == 0) push_init(1'b1);
            kind = $urandom_range(99);
            kind = (kind < 70) ? FR_GOOD : (kind < 85) ? FR_BAD_CRC :
                   (kind < 90) ? FR_ALL_FF : (kind < 95) ? FR_ALL_00 : FR_CUT;
            queue_frame(kind, pick_raw());
            if (kind != FR_GOOD && $urandom_range(9) < 6) push_init(1'b1);
         end else if (pick < 70) begin
            push_fail(1'($urandom));
            if ($urandom_range(1)) push_init(1'b1);
         end else if (pick < 82) begin
            push_init($urandom_range(9) < 8);
         end else if (pick < 86) begin
            push_event(CMD_SPARE, 8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            if ($urandom_range(3) != 0) push_init(1'b1);
         end
      end
   endtask

   task automatic wait_idle();
      while (bus_events.size() != 0 || req_if.valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      wait_idle();
      csr_if.valid       <= 1'b1;
      csr_if.error_limit <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      limit_writes++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 14;
      recv_idle_pct <= 46;

      push_init(1'b0);
      push_byte(8'h5A);
      push_fail(1'b1);
      push_event(CMD_SPARE, 8'hA5, 1'b1, 1'b1);
      push_init(1'b1);
      queue_frame(FR_GOOD, 16'h7FFF);
      queue_frame(FR_ALL_00, 16'h0000);
      push_fail(1'b0);
      push_fail(1'b1);

      write_limit(8'd1);
      random_traffic(100);
      holds_asked <= holds_asked + 1;

      write_limit(8'd255);
      push_init(1'b1);
      queue_frame(FR_GOOD, 16'hFFFF);
      repeat (258) push_fail(1'($urandom));
      queue_frame(FR_GOOD, 16'h8000);
      push_init(1'b0);
      push_init(1'b1);
      queue_frame(FR_GOOD, 16'h8000);

      write_limit(8'($urandom_range(2, 254)));
      send_idle_pct <= 46;
      recv_idle_pct <= 14;
      random_traffic(100);
      holds_asked <= holds_asked + 1;

      write_limit(8'd2);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      random_traffic(100);

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d bus events into %0d status reports over %0d error-limit settings,",
               events_taken, reports_seen, limit_writes + 1);
      $display("with good, corrupted, blank and cut frames, failures, rejects and long stalls.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
